// File: sv/flphm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flphm_pkg: shared types and constants of the FNV hash map
// Operation codes, status codes, FNV constants and the front-to-back command.
// ----------------------------------------------------------------------------
package flphm_pkg;

  localparam int unsigned KindW   = 2;
  localparam int unsigned KeyW    = 64;
  localparam int unsigned LenW    = 4;
  localparam int unsigned ValInW  = 16;
  localparam int unsigned StatusW = 2;

  localparam logic [KindW-1:0] KIND_INSERT = 2'd0;
  localparam logic [KindW-1:0] KIND_LOOKUP = 2'd1;
  localparam logic [KindW-1:0] KIND_CLEAR  = 2'd2;
  localparam logic [KindW-1:0] KIND_NONE   = 2'd3;

  localparam logic [StatusW-1:0] ST_OK   = 2'd0;
  localparam logic [StatusW-1:0] ST_DUP  = 2'd1;
  localparam logic [StatusW-1:0] ST_FULL = 2'd2;
  localparam logic [StatusW-1:0] ST_MISS = 2'd3;

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_LOOKUP,
    OP_CLEAR,
    OP_NOP
  } op_e;

  // Hashed command handed from the front end to the probe engine.
  typedef struct packed {
    op_e             op;
    logic [31:0]     hash;
    logic [KeyW-1:0] key;
    logic [LenW-1:0] len;
    logic [ValInW-1:0] value;
  } cmd_t;

endpackage

// File: sv/fnv_linear_probe_hash_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fnv_linear_probe_hash_map: open-addressing hash map with FNV-1a keys
// Inserts, looks up or clears short byte-string keys mapped to small values.
// ----------------------------------------------------------------------------
// Usage: one request beat on s_axis (kind in tuser, key/len/value in tdata)
// gives exactly one result beat on m_axis (status in tuser, value in tdata).
// The front end hashes one key byte a cycle, then hands the command through
// a two-entry queue to the probe engine. The engine reads each probed
// bucket from registered memory in S_READ and compares it in S_CHECK; a
// clear passes through S_CLEAR only. Front and engine work on separate items.
// Reset empties the table (bucket valid flags cleared at once) and sets
// table_log2 to 8. When m_axis_tready is low the result is held, the engine
// stalls and the queue fills, after which s_axis_tready drops.
// table_log2 must be written with cfg_we_i only while the block is idle;
// the block itself does not enforce this.
// ----------------------------------------------------------------------------
module fnv_linear_probe_hash_map #(
  parameter int unsigned MAX_TABLE_LOG2 = 8,
  parameter int unsigned MAX_KEY_BYTES  = 8,
  parameter int unsigned VALUE_BITS     = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,      // table_log2
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [87:0] s_axis_tdata,     // key_bytes[63:0], key_len[67:64], entry_value[83:68]
  input  logic [1:0]  s_axis_tuser,     // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,     // found_value
  output logic [1:0]  m_axis_tuser      // status
);
  import flphm_pkg::*;

  logic [3:0] table_log2_q;
  logic       f_valid, f_ready, b_valid, b_ready;
  cmd_t       f_cmd, b_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_log2_q <= 4'd8;
    end else if (cfg_we_i) begin
      table_log2_q <= cfg_wdata_i;
    end
  end

  flphm_front #(.MaxKeyBytes(MAX_KEY_BYTES)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .kind_i     (s_axis_tuser),
    .key_i      (s_axis_tdata[63:0]),
    .len_i      (s_axis_tdata[67:64]),
    .value_i    (s_axis_tdata[83:68]),
    .cmd_valid_o(f_valid),
    .cmd_ready_i(f_ready),
    .cmd_o      (f_cmd)
  );

  flphm_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(f_valid),
    .wr_ready_o(f_ready),
    .wr_data_i (f_cmd),
    .rd_valid_o(b_valid),
    .rd_ready_i(b_ready),
    .rd_data_o (b_cmd)
  );

  flphm_back #(.MaxTableLog2(MAX_TABLE_LOG2), .ValueBits(VALUE_BITS)) u_back (
    .clk_i, .rst_ni,
    .table_log2_i (table_log2_q),
    .cmd_valid_i  (b_valid),
    .cmd_ready_o  (b_ready),
    .cmd_i        (b_cmd),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .status_o     (m_axis_tuser),
    .found_value_o(m_axis_tdata)
  );

endmodule

// File: sv/flphm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flphm_front: key normalization and FNV-1a hash
// Takes one request beat, masks the key, hashes one byte a cycle.
// ----------------------------------------------------------------------------
module flphm_front #(
  parameter int unsigned MaxKeyBytes = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [flphm_pkg::KindW-1:0] kind_i,
  input  logic [flphm_pkg::KeyW-1:0]  key_i,
  input  logic [flphm_pkg::LenW-1:0]  len_i,
  input  logic [flphm_pkg::ValInW-1:0] value_i,
  output logic                        cmd_valid_o,
  input  logic                        cmd_ready_i,
  output flphm_pkg::cmd_t             cmd_o
);
  import flphm_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_HASH,
    S_SEND
  } state_e;

  state_e          state_q;
  cmd_t            cmd_q;
  logic [LenW-1:0] cnt_q;
  logic [LenW-1:0] len_sat;
  logic [KeyW-1:0] key_m;
  logic [7:0]      cur_byte;
  logic [31:0]     hash_x;

  always_comb begin
    len_sat = (len_i > LenW'(MaxKeyBytes)) ? LenW'(MaxKeyBytes) : len_i;
    for (int i = 0; i < KeyW / 8; i++) begin
      key_m[i*8 +: 8] = (LenW'(i) < len_sat) ? key_i[i*8 +: 8] : 8'h00;
    end
  end

  assign cur_byte    = cmd_q.key[cnt_q[2:0]*8 +: 8];
  assign hash_x      = cmd_q.hash ^ {24'h0, cur_byte};
  assign in_ready_o  = (state_q == S_IDLE);
  assign cmd_valid_o = (state_q == S_SEND);
  assign cmd_o       = cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            case (kind_i)
              KIND_INSERT: cmd_q.op <= OP_INSERT;
              KIND_LOOKUP: cmd_q.op <= OP_LOOKUP;
              KIND_CLEAR:  cmd_q.op <= OP_CLEAR;
              default:     cmd_q.op <= OP_NOP;
            endcase
            cmd_q.hash  <= FNV_BASIS;
            cmd_q.key   <= key_m;
            cmd_q.len   <= len_sat;
            cmd_q.value <= value_i;
            cnt_q       <= '0;
            state_q     <= S_HASH;
          end
        end
        S_HASH: begin
          if (cnt_q == cmd_q.len) begin
            state_q <= S_SEND;
          end else begin
            cmd_q.hash <= hash_x * FNV_PRIME;
            cnt_q      <= cnt_q + 1'b1;
          end
        end
        S_SEND: begin
          if (cmd_ready_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// File: sv/flphm_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flphm_queue: two-entry command queue
// Decouples the hash front end from the probe engine.
// ----------------------------------------------------------------------------
module flphm_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_valid_i,
  output logic            wr_ready_o,
  input  flphm_pkg::cmd_t wr_data_i,
  output logic            rd_valid_o,
  input  logic            rd_ready_i,
  output flphm_pkg::cmd_t rd_data_o
);
  import flphm_pkg::*;

  cmd_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       do_wr, do_rd;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_data_o  = mem_q[rp_q];
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (do_wr) wp_q <= ~wp_q;
      if (do_rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end

endmodule

// File: sv/flphm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flphm_back: probe engine over the bucket memory
// Walks buckets linearly, one memory read per probe, and answers each command.
// ----------------------------------------------------------------------------
module flphm_back #(
  parameter int unsigned MaxTableLog2 = 8,
  parameter int unsigned ValueBits    = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [3:0]                    table_log2_i,
  input  logic                          cmd_valid_i,
  output logic                          cmd_ready_o,
  input  flphm_pkg::cmd_t               cmd_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output logic [flphm_pkg::StatusW-1:0] status_o,
  output logic [flphm_pkg::ValInW-1:0]  found_value_o
);
  import flphm_pkg::*;

  // Values arrive as 16 bits, so a wider setting stores no more than that.
  localparam int unsigned StoreW = (ValueBits < ValInW) ? ValueBits : ValInW;
  localparam int unsigned Depth = 1 << MaxTableLog2;
  localparam int unsigned IdxW  = MaxTableLog2;
  localparam int unsigned CntW  = MaxTableLog2 + 1;
  localparam int unsigned EntW  = KeyW + LenW + StoreW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_CLEAR,
    S_OUT
  } state_e;

  state_e                state_q;
  cmd_t                  cmd_q;
  logic [IdxW-1:0]       idx_q, mask_q;
  logic [CntW-1:0]       steps_q, cap_q;
  logic [Depth-1:0]      used_q;
  logic                  used_rd_q;
  logic [EntW-1:0]       mem [Depth];
  logic [EntW-1:0]       rd_q;
  logic                  wr_en;
  logic [EntW-1:0]       wr_data;
  logic [StatusW-1:0]    status_q;
  logic [ValInW-1:0]     fval_q;
  logic [4:0]            lg_sat;
  logic [IdxW-1:0]       mask_d;
  logic                  key_hit;
  logic [CntW-1:0]       steps_nx;
  logic [StoreW-1:0]     rd_val;

  assign lg_sat = (int'(table_log2_i) > MaxTableLog2) ? 5'(MaxTableLog2)
                                                      : {1'b0, table_log2_i};
  assign mask_d = IdxW'((CntW'(1) << lg_sat) - CntW'(1));
  assign rd_val = rd_q[StoreW-1:0];
  assign key_hit = (rd_q[EntW-1 -: KeyW] == cmd_q.key)
                && (rd_q[StoreW +: LenW] == cmd_q.len);
  assign steps_nx = steps_q + 1'b1;
  assign wr_en   = (state_q == S_CHECK) && !used_rd_q && (cmd_q.op == OP_INSERT);
  assign wr_data = {cmd_q.key, cmd_q.len, cmd_q.value[StoreW-1:0]};

  assign cmd_ready_o   = (state_q == S_IDLE);
  assign res_valid_o   = (state_q == S_OUT);
  assign status_o      = status_q;
  assign found_value_o = fval_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[idx_q] <= wr_data;
    rd_q <= mem[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      used_q    <= '0;
      used_rd_q <= 1'b0;
      status_q  <= ST_OK;
      fval_q    <= '0;
      idx_q     <= '0;
      mask_q    <= '0;
      steps_q   <= '0;
      cap_q     <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            cmd_q    <= cmd_i;
            mask_q   <= mask_d;
            cap_q    <= CntW'(1) << lg_sat;
            idx_q    <= cmd_i.hash[IdxW-1:0] & mask_d;
            steps_q  <= '0;
            fval_q   <= '0;
            status_q <= ST_OK;
            case (cmd_i.op)
              OP_INSERT, OP_LOOKUP: state_q <= S_READ;
              OP_CLEAR:             state_q <= S_CLEAR;
              default:              state_q <= S_OUT;
            endcase
          end
        end
        S_READ: begin
          // Memory read of idx_q lands in rd_q for the check cycle.
          used_rd_q <= used_q[idx_q];
          state_q   <= S_CHECK;
        end
        S_CHECK: begin
          if (!used_rd_q) begin
            if (cmd_q.op == OP_INSERT) begin
              used_q[idx_q] <= 1'b1;
              status_q      <= ST_OK;
            end else begin
              status_q <= ST_MISS;
            end
            state_q <= S_OUT;
          end else if (key_hit) begin
            if (cmd_q.op == OP_INSERT) begin
              status_q <= ST_DUP;
            end else begin
              status_q <= ST_OK;
              fval_q   <= ValInW'(rd_val);
            end
            state_q <= S_OUT;
          end else if (steps_nx >= cap_q) begin
            status_q <= (cmd_q.op == OP_INSERT) ? ST_FULL : ST_MISS;
            state_q  <= S_OUT;
          end else begin
            idx_q   <= (idx_q + 1'b1) & mask_q;
            steps_q <= steps_nx;
            state_q <= S_READ;
          end
        end
        S_CLEAR: begin
          used_q  <= '0;
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (res_ready_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// File: tb/flphm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flphm_checker: result checker for the FNV hash map
// Watches request and result beats, keeps its own copy of the table and the
// capacity setting, predicts each result and compares it in order.
// ----------------------------------------------------------------------------
module flphm_checker (
  input  logic        clk_i,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [87:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,
  input  logic [1:0]  m_axis_tuser,
  output int          fail_count_o,
  output int          pending_o
);
  import flphm_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] value;
  } answer_t;

  localparam int Depth = 256;

  logic [3:0]  model_log2 = 4'd8;
  logic        model_used [Depth];
  logic [63:0] model_key [Depth];
  logic [3:0]  model_len [Depth];
  logic [15:0] model_val [Depth];
  answer_t     answer_q [$];
  int          fails = 0;

  assign fail_count_o = fails;
  assign pending_o    = answer_q.size();

  initial begin
    for (int i = 0; i < Depth; i++) model_used[i] = 1'b0;
  end

  function automatic logic [31:0] fnv_hash(logic [63:0] k, int n);
    logic [31:0] h;
    h = FNV_BASIS;
    for (int i = 0; i < n; i++) begin
      h = (h ^ {24'd0, k[8*i +: 8]}) * FNV_PRIME;
    end
    return h;
  endfunction

  function automatic answer_t apply_request(logic [1:0] kind, logic [87:0] d);
    answer_t     a;
    int          n, lg, cap, idx, steps;
    logic [63:0] k;
    a  = '{status: ST_OK, value: 16'd0};
    n  = (d[67:64] > 8) ? 8 : int'(d[67:64]);
    lg = (model_log2 > 8) ? 8 : int'(model_log2);
    cap = 1 << lg;
    k = (n == 8) ? d[63:0] : (d[63:0] & ((64'd1 << (8 * n)) - 64'd1));
    if (kind == KIND_CLEAR) begin
      for (int i = 0; i < Depth; i++) model_used[i] = 1'b0;
    end else if (kind == KIND_INSERT || kind == KIND_LOOKUP) begin
      idx = int'(fnv_hash(k, n) & (cap - 1));
      steps = 0;
      a.status = (kind == KIND_INSERT) ? ST_OK : ST_MISS;
      forever begin
        if (!model_used[idx]) begin
          if (kind == KIND_INSERT) begin
            model_used[idx] = 1'b1;
            model_key[idx]  = k;
            model_len[idx]  = 4'(n);
            model_val[idx]  = d[83:68];
          end
          break;
        end
        if (model_len[idx] == 4'(n) && model_key[idx] == k) begin
          if (kind == KIND_INSERT) a.status = ST_DUP;
          else begin
            a.status = ST_OK;
            a.value  = model_val[idx];
          end
          break;
        end
        idx = (idx + 1) & (cap - 1);
        steps++;
        if (steps >= cap) begin
          a.status = (kind == KIND_INSERT) ? ST_FULL : ST_MISS;
          break;
        end
      end
    end
    return a;
  endfunction

  always @(posedge clk_i) begin
    answer_t exp_a;
    if (cfg_we_i) model_log2 <= cfg_wdata_i;
    if (s_axis_tvalid && s_axis_tready) begin
      answer_q.push_back(apply_request(s_axis_tuser, s_axis_tdata));
    end
    if (m_axis_tvalid && m_axis_tready) begin
      if (answer_q.size() == 0) begin
        $display("%0t: result beat with nothing expected: status %0d value %0h",
                 $time, m_axis_tuser, m_axis_tdata);
        fails++;
      end else begin
        exp_a = answer_q.pop_front();
        if (m_axis_tuser !== exp_a.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_a.status,
                   m_axis_tuser);
          fails++;
        end
        if (m_axis_tdata !== exp_a.value) begin
          $display("%0t: found_value expected %0h actual %0h", $time, exp_a.value,
                   m_axis_tdata);
          fails++;
        end
      end
    end
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for the FNV hash map
// Directed and random insert, lookup, clear and no-op traffic over several table
// sizes, with random gaps on both sides, checked by a separate checker.
// ----------------------------------------------------------------------------
module tb;
  import flphm_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [3:0]  cfg_wdata = 4'd0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [87:0] s_data = '0;
  logic [1:0]  s_user = '0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [15:0] m_data;
  logic [1:0]  m_user;
  int          fail_count, pending;
  bit          no_gaps = 1'b0;
  bit          stim_done = 1'b0;

  // Small pool of keys so that hits and collisions are common.
  logic [63:0] key_pool [16];
  logic [3:0]  len_pool [16];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  fnv_linear_probe_hash_map uut (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .s_axis_tvalid(s_valid), .s_axis_tready(s_ready), .s_axis_tdata(s_data),
    .s_axis_tuser(s_user), .m_axis_tvalid(m_valid), .m_axis_tready(m_ready),
    .m_axis_tdata(m_data), .m_axis_tuser(m_user)
  );

  flphm_checker chk (
    .clk_i(clk), .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .s_axis_tvalid(s_valid), .s_axis_tready(s_ready), .s_axis_tdata(s_data),
    .s_axis_tuser(s_user), .m_axis_tvalid(m_valid), .m_axis_tready(m_ready),
    .m_axis_tdata(m_data), .m_axis_tuser(m_user),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Result side stalls in random bursts.
  initial begin
    int gap;
    forever begin
      @(posedge clk);
      if (!no_gaps && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 13);
        m_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_ready <= 1'b1;
    end
  end

  task automatic send_beat(logic [1:0] kind, logic [63:0] k, logic [3:0] n,
                           logic [15:0] v);
    int gap;
    if (!no_gaps && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 13);
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_user  <= kind;
    s_data  <= {4'd0, v, n, k};
    do @(posedge clk); while (!s_ready);
  endtask

  task automatic go_idle();
    s_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_capacity(logic [3:0] lg);
    go_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= lg;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_beat();
    int          pick, r;
    logic [63:0] k;
    logic [3:0]  n;
    pick = $urandom_range(0, 15);
    k = key_pool[pick];
    n = len_pool[pick];
    r = $urandom_range(0, 99);
    if (r < 10) begin
      // Stray bytes above the length must not matter.
      k = {$urandom, $urandom};
    end else if (r < 18) begin
      k = {$urandom, $urandom};
      n = 4'($urandom_range(0, 15));
    end
    r = $urandom_range(0, 99);
    if (r < 45) send_beat(KIND_INSERT, k, n, 16'($urandom));
    else if (r < 93) send_beat(KIND_LOOKUP, k, n, 16'($urandom));
    else if (r < 97) send_beat(KIND_NONE, k, n, 16'($urandom));
    else send_beat(KIND_CLEAR, k, n, 16'($urandom));
  endtask

  initial begin
    logic [3:0] sizes [6];
    sizes = '{4'd2, 4'd0, 4'd15, 4'd1, 4'd4, 4'd8};
    for (int i = 0; i < 16; i++) begin
      key_pool[i] = {$urandom, $urandom};
      len_pool[i] = 4'($urandom_range(0, 8));
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, every operation, empty key, zero bytes, overlong key.
    send_beat(KIND_LOOKUP, 64'd0, 4'd0, 16'd0);
    send_beat(KIND_INSERT, 64'd0, 4'd0, 16'hFFFF);
    send_beat(KIND_INSERT, 64'd0, 4'd0, 16'h1234);
    send_beat(KIND_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 16'd0);
    send_beat(KIND_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 16'hA5A5);
    send_beat(KIND_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 16'd0);
    send_beat(KIND_INSERT, 64'h0000_0000_0000_0000, 4'd3, 16'h0001);
    send_beat(KIND_LOOKUP, 64'hFF00_0000_0000_0000, 4'd3, 16'd0);
    send_beat(KIND_LOOKUP, 64'd0, 4'd2, 16'd0);
    send_beat(KIND_NONE, 64'h1234, 4'd2, 16'hFFFF);
    send_beat(KIND_CLEAR, 64'd0, 4'd0, 16'd0);
    send_beat(KIND_LOOKUP, 64'd0, 4'd0, 16'd0);
    send_beat(KIND_INSERT, 64'h5A5A_5A5A_5A5A_5A5A, 4'd9, 16'h8000);

    // One bucket: second insert finds the table full.
    set_capacity(4'd0);
    send_beat(KIND_INSERT, 64'h41, 4'd1, 16'h0042);
    send_beat(KIND_INSERT, 64'h42, 4'd1, 16'h0043);
    send_beat(KIND_LOOKUP, 64'h42, 4'd1, 16'd0);
    send_beat(KIND_LOOKUP, 64'h41, 4'd1, 16'd0);
    // Bigger capacity while filled: old buckets stay.
    set_capacity(4'd3);
    send_beat(KIND_LOOKUP, 64'h41, 4'd1, 16'd0);
    send_beat(KIND_INSERT, 64'h42, 4'd1, 16'h0043);

    for (int phase = 0; phase < 6; phase++) begin
      set_capacity(sizes[phase]);
      for (int i = 0; i < 225; i++) begin
        if (phase == 5 && i == 150) no_gaps = 1'b1;
        random_beat();
      end
    end
    s_valid <= 1'b0;
    @(posedge clk);
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb: errors");
    $finish;
  end

endmodule

// File: fnv_linear_probe_hash_map.f
sv/flphm_pkg.sv
sv/flphm_front.sv
sv/flphm_queue.sv
sv/flphm_back.sv
sv/fnv_linear_probe_hash_map.sv
tb/flphm_checker.sv
tb/tb.sv
